/* sv/sca_pkg.sv */
package sca_pkg;

    // Fixed field widths of the ports
    localparam int SIZE_W     = 13;
    localparam int REL_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int ADDR_W     = 20;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam int MAXA_W     = 11;
    localparam int LIMIT_W    = 9;

    // Default geometry
    localparam int DEF_NUM_PAGES    = 256;
    localparam int DEF_PAGE_BYTES   = 4096;
    localparam int DEF_MIN_ALLOC    = 16;
    localparam int DEF_NUM_CLASSES  = 64;
    localparam int DEF_HEADER_BYTES = 32;

    // Register reset values
    localparam int RST_MAX_ALLOC  = 1024;
    localparam int RST_PAGE_LIMIT = 256;

    // Opcodes
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_PAGE  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ALLOC  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_LIMIT = 1'd1;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch the accepted item, compute its class
        logic decode;    // check the class, issue memory reads, push a release
        logic commit;    // update class state and load the output register
    } sca_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_busy;  // output register holds a result not yet taken
    } sca_stat_t;

    // First block offset in a page: header rounded up to the block size.
    // Elaboration only.
    function automatic int sca_first_offset(input int bs, input int hdr);
        int acc;
        acc = bs;
        for (int i = 0; i < 256; i++)
        begin
            if (acc < hdr)
            begin
                acc = acc + bs;
            end
        end
        return acc;
    endfunction

endpackage

/* sv/sca_ram.sv */
module sca_ram
    import sca_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/sca_ctrl.sv */
module sca_ctrl
    import sca_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      out_ready,
    input  sca_stat_t stat,
    output sca_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_GRANT  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       commit;

    assign in_ready = (state_reg == S_IDLE);
    // hold in GRANT until the output register can take the result
    assign commit   = (state_reg == S_GRANT) && (!stat.out_busy || out_ready);

    assign cmd.capture = in_valid && in_ready;
    assign cmd.decode  = (state_reg == S_DECODE);
    assign cmd.commit  = commit;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_GRANT;
            end
            S_GRANT:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/sca_datapath.sv */
module sca_datapath
    import sca_pkg::*;
#(
    parameter int NUM_PAGES    = DEF_NUM_PAGES,
    parameter int PAGE_BYTES   = DEF_PAGE_BYTES,
    parameter int MIN_ALLOC    = DEF_MIN_ALLOC,
    parameter int NUM_CLASSES  = DEF_NUM_CLASSES,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sca_cmd_t              cmd,
    output sca_stat_t             stat,
    input  logic                  opcode,
    input  logic [SIZE_W-1:0]     request_size,
    input  logic [REL_W-1:0]      release_page,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATUS_W-1:0]   status,
    output logic [ADDR_W-1:0]     block_address,
    output logic                  page_closed
);

    localparam int PAGE_W = $clog2(NUM_PAGES);
    localparam int CNT_W  = $clog2(NUM_PAGES + 1);
    localparam int PB_W   = $clog2(PAGE_BYTES + 1);
    localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int TAB_N  = 2 ** CLS_W;
    localparam int QW     = 14 - $clog2(MIN_ALLOC);
    localparam int CW     = PAGE_W + PB_W;
    // exact quotient by MIN_ALLOC for 13-bit numerators: multiply and shift
    localparam int DIV_SH  = SIZE_W + $clog2(MIN_ALLOC);
    localparam int DIV_MUL = (2 ** DIV_SH + MIN_ALLOC - 1) / MIN_ALLOC;
    localparam int LIM_RST = (RST_PAGE_LIMIT > NUM_PAGES) ? NUM_PAGES : RST_PAGE_LIMIT;
    localparam int MAXC_RST = (RST_MAX_ALLOC + MIN_ALLOC - 1) / MIN_ALLOC;

    // per-class constant tables
    logic [PB_W-1:0] bs_tab    [TAB_N];
    logic [PB_W-1:0] first_tab [TAB_N];
    logic [TAB_N-1:0] fit_tab;

    for (genvar c = 0; c < TAB_N; c++)
    begin : g_tab
        localparam int BS    = (c + 1) * MIN_ALLOC;
        localparam int FIRST = sca_first_offset(BS, HEADER_BYTES);
        localparam bit FIT   = (c < NUM_CLASSES) && (FIRST + BS <= PAGE_BYTES);
        assign bs_tab[c]    = FIT ? PB_W'(BS) : '0;
        assign first_tab[c] = FIT ? PB_W'(FIRST) : '0;
        assign fit_tab[c]   = FIT;
    end

    // configuration
    logic [QW-1:0]    max_cls_reg;
    logic [CNT_W-1:0] lim_reg;
    logic [31:0]      max_prod;

    assign cfg_ready = 1'b1;
    assign max_prod  = (32'(cfg_data) + 32'(MIN_ALLOC - 1)) * 32'(DIV_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_cls_reg <= QW'(MAXC_RST);
            lim_reg     <= CNT_W'(LIM_RST);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_MAX_ALLOC)
            begin
                max_cls_reg <= QW'(max_prod >> DIV_SH);
            end
            else if (cfg_index == REG_PAGE_LIMIT)
            begin
                lim_reg <= (32'(cfg_data[LIMIT_W-1:0]) > 32'(NUM_PAGES)) ?
                           CNT_W'(NUM_PAGES) : CNT_W'(cfg_data[LIMIT_W-1:0]);
            end
        end
    end

    // item capture
    logic              op_reg;
    logic              zero_reg;
    logic [QW-1:0]     cls_q_reg;
    logic [REL_W-1:0]  rel_reg;
    logic              bad_reg;
    logic [31:0]       cls_prod;
    logic [CLS_W-1:0]  cls_idx;

    assign cls_prod = (32'(request_size) - 32'd1) * 32'(DIV_MUL);
    assign cls_idx  = CLS_W'(cls_q_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= opcode;
            zero_reg  <= (request_size == '0);
            cls_q_reg <= QW'(cls_prod >> DIV_SH);
            rel_reg   <= release_page;
        end
        if (cmd.decode)
        begin
            bad_reg <= zero_reg || (cls_q_reg >= max_cls_reg)
                       || (32'(cls_q_reg) >= 32'(NUM_CLASSES)) || !fit_tab[cls_idx];
        end
    end

    // page pool
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  fresh_reg;
    logic [CNT_W-1:0]  fresh_next;
    logic              push;
    logic [PAGE_W-1:0] stack_rdata;

    assign push = cmd.decode && (op_reg == OP_RELEASE) && (rel_reg != '0)
                  && (32'(rel_reg) < 32'(lim_reg)) && (32'(count_reg) < 32'(NUM_PAGES));

    sca_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (NUM_PAGES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (push),
        .waddr (PAGE_W'(count_reg)),
        .wdata (PAGE_W'(rel_reg)),
        .raddr (PAGE_W'(count_reg - CNT_W'(1))),
        .rdata (stack_rdata)
    );

    // per-class open page and offset
    logic [TAB_N-1:0] open_reg;
    logic             cram_we;
    logic [CW-1:0]    cram_wdata;
    logic [CW-1:0]    cram_rdata;

    sca_ram #(
        .WIDTH (CW),
        .DEPTH (TAB_N)
    ) u_class_ram (
        .clk   (clk),
        .we    (cram_we),
        .waddr (cls_idx),
        .wdata (cram_wdata),
        .raddr (cls_idx),
        .rdata (cram_rdata)
    );

    // grant
    logic [STATUS_W-1:0] st_sel;
    logic                grant;
    logic                pop;
    logic                bump;
    logic [PAGE_W-1:0]   page_sel;
    logic [PB_W-1:0]     off_sel;
    logic [PB_W-1:0]     bs_sel;
    logic [PB_W:0]       new_off;
    logic [PB_W+1:0]     end_off;
    logic                closed;
    logic [ADDR_W-1:0]   addr_calc;

    always_comb
    begin
        st_sel   = ST_OK;
        grant    = 1'b0;
        pop      = 1'b0;
        bump     = 1'b0;
        page_sel = cram_rdata[CW-1:PB_W];
        off_sel  = cram_rdata[PB_W-1:0];
        if (op_reg == OP_ALLOC)
        begin
            if (bad_reg)
            begin
                st_sel = ST_BAD_SIZE;
            end
            else if (open_reg[cls_idx])
            begin
                grant = 1'b1;
            end
            else if (count_reg != '0)
            begin
                grant    = 1'b1;
                pop      = 1'b1;
                page_sel = stack_rdata;
                off_sel  = first_tab[cls_idx];
            end
            else if (fresh_reg < lim_reg)
            begin
                grant    = 1'b1;
                bump     = 1'b1;
                page_sel = PAGE_W'(fresh_reg);
                off_sel  = first_tab[cls_idx];
            end
            else
            begin
                st_sel = ST_NO_PAGE;
            end
        end
    end

    assign bs_sel     = bs_tab[cls_idx];
    assign new_off    = {1'b0, off_sel} + {1'b0, bs_sel};
    assign end_off    = {1'b0, new_off} + {2'b00, bs_sel};
    assign closed     = end_off > (PB_W + 2)'(PAGE_BYTES);
    assign addr_calc  = ADDR_W'(ADDR_W'(page_sel) * ADDR_W'(PAGE_BYTES)) + ADDR_W'(off_sel);
    assign cram_we    = cmd.commit && grant;
    assign cram_wdata = {page_sel, PB_W'(new_off)};

    always_comb
    begin
        count_next = count_reg;
        fresh_next = fresh_reg;
        if (push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.commit && pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.commit && bump)
        begin
            fresh_next = fresh_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            fresh_reg <= CNT_W'(1);
            open_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            fresh_reg <= fresh_next;
            if (cram_we)
            begin
                open_reg[cls_idx] <= !closed;
            end
        end
    end

    // output register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                closed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg <= st_sel;
            addr_reg   <= grant ? addr_calc : '0;
            closed_reg <= grant && closed;
        end
    end

    assign stat.out_busy = out_valid_reg;
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign block_address = addr_reg;
    assign page_closed   = closed_reg;

endmodule

/* sv/size_class_block_allocator_top.sv */
// Size-class block allocator. Each input transfer is either an allocate request
// (opcode 0, request_size in bytes) or the release of a whole page (opcode 1,
// release_page). Requests map to size classes of MIN_ALLOC bytes; each class
// carves blocks out of its open page, and opens a new one from the released-page
// stack (last released first) or the fresh-page counter when it has none. Page 0
// is reserved and never handed out. Every input transfer produces exactly one
// result transfer: status 0 with block_address and page_closed on a grant,
// status 1 for a zero, oversized or unplaceable size, status 2 when no page is
// left; a release always answers status 0 with zero address. From input
// transfer to result an item is captured and its class computed, then the
// per-class memory and the page stack give their registered reads, and last
// the class state is updated and the result of the item is loaded into the
// output register. The output register lets the next item be taken while a
// result waits; a stalled output holds the item in its last step. No clearing
// pass runs after reset: the page stack and per-class page/offset memories are
// only read after being written, and the per-class open flags are flops.
// Configuration writes (index 0 max_alloc_size, index 1 page_limit) are always
// ready and must only be issued while the block is idle.
module size_class_block_allocator_top
    import sca_pkg::*;
#(
    parameter int NUM_PAGES    = DEF_NUM_PAGES,
    parameter int PAGE_BYTES   = DEF_PAGE_BYTES,
    parameter int MIN_ALLOC    = DEF_MIN_ALLOC,
    parameter int NUM_CLASSES  = DEF_NUM_CLASSES,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  opcode,
    input  logic [SIZE_W-1:0]     request_size,
    input  logic [REL_W-1:0]      release_page,
    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATUS_W-1:0]   status,
    output logic [ADDR_W-1:0]     block_address,
    output logic                  page_closed,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    sca_cmd_t  cmd;
    sca_stat_t stat;

    // sequence each item through capture, decode and grant
    sca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // class math, page pool, class memories and the output register
    sca_datapath #(
        .NUM_PAGES    (NUM_PAGES),
        .PAGE_BYTES   (PAGE_BYTES),
        .MIN_ALLOC    (MIN_ALLOC),
        .NUM_CLASSES  (NUM_CLASSES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .opcode        (opcode),
        .request_size  (request_size),
        .release_page  (release_page),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .block_address (block_address),
        .page_closed   (page_closed)
    );

endmodule

/* sv/sca_checker.sv */
module sca_checker
    import sca_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STATUS_W-1:0] status,
    input logic [ADDR_W-1:0]   block_address,
    input logic                page_closed
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(block_address) && $stable(page_closed))
        else $error("stalled result changed");

    // no address and no close flag without a grant
    a_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (block_address == '0) && !page_closed)
        else $error("failed result carries a block");

    // one item at a time: input closed for decode and grant
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("input taken while an item is in flight");

endmodule

bind size_class_block_allocator_top sca_checker u_sca_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .block_address (block_address),
    .page_closed   (page_closed)
);
